// ===== rtl/msct_pkg.sv =====
// Shared types and constants for the minutes:seconds countdown timer.
`default_nettype none

package msct_pkg;

    localparam int unsigned CountWidth = 16;
    localparam int unsigned TimeWidth  = 8;
    localparam int unsigned ReqWidth   = 3;
    localparam int unsigned CfgIdxWidth = 2;
    localparam int unsigned CfgDataWidth = 16;

    localparam logic [CountWidth-1:0] CompareTopReset = 16'd14399;
    localparam logic [TimeWidth-1:0]  MaxMinutesReset = 8'd80;
    localparam logic [TimeWidth-1:0]  SecondsTop      = 8'd59;

    typedef enum logic [CfgIdxWidth-1:0] {
        CFG_COMPARE_TOP = 2'd0,
        CFG_MAX_MINUTES = 2'd1
    } cfg_idx_t;

    typedef enum logic [ReqWidth-1:0] {
        REQ_TICK    = 3'd0,
        REQ_SET     = 3'd1,
        REQ_ADD_MIN = 3'd2,
        REQ_ADD_SEC = 3'd3,
        REQ_CLEAR   = 3'd4,
        REQ_PAUSE   = 3'd5,
        REQ_RESUME  = 3'd6
    } req_t;

    typedef struct packed {
        logic [ReqWidth-1:0]  req_type;
        logic [TimeWidth-1:0] value_minutes;
        logic [TimeWidth-1:0] value_seconds;
    } item_t;

    typedef struct packed {
        logic [TimeWidth-1:0] minutes;
        logic [TimeWidth-1:0] seconds;
        logic                 is_zero;
        logic                 running;
        logic                 armed;
        logic                 second_step;
    } result_t;

endpackage

`default_nettype wire

// ===== rtl/msct_input_stage.sv =====
// Input register: captures one request word per cycle unless in_stall holds it.
`default_nettype none

module msct_input_stage
    import msct_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 in_valid,
    output logic                      in_stall,
    input  wire logic [ReqWidth-1:0]  req_type,
    input  wire logic [TimeWidth-1:0] value_minutes,
    input  wire logic [TimeWidth-1:0] value_seconds,
    input  wire logic                 advance,
    output logic                      item_valid,
    output item_t                     item
);

    logic  valid_reg;
    item_t item_reg;

    assign in_stall   = valid_reg && !advance;
    assign item_valid = valid_reg;
    assign item       = item_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (!in_stall)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall)
        begin
            item_reg.req_type      <= req_type;
            item_reg.value_minutes <= value_minutes;
            item_reg.value_seconds <= value_seconds;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/msct_engine.sv =====
// Timer state, configuration registers and the next-state logic per request.
`default_nettype none

module msct_engine
    import msct_pkg::*;
(
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic                    cfg_we,
    input  wire logic [CfgIdxWidth-1:0]  cfg_index,
    input  wire logic [CfgDataWidth-1:0] cfg_data,
    input  wire logic                    advance,
    input  item_t                        item,
    output result_t                      result
);

    logic [CountWidth-1:0] compare_top_reg;
    logic [TimeWidth-1:0]  max_minutes_reg;

    logic [CountWidth-1:0] count_reg, count_next;
    logic [TimeWidth-1:0]  min_reg, min_next;
    logic [TimeWidth-1:0]  sec_reg, sec_next;
    logic                  run_reg, run_next;
    logic                  arm_reg, arm_next;
    logic                  step;

    logic [TimeWidth-1:0] min_sum;
    logic [TimeWidth-1:0] sec_sum;
    logic [2:0]           sec_carry;
    logic [TimeWidth-1:0] sec_rem;
    logic [TimeWidth-1:0] carry_sum;

    // Seconds sum split into carry minutes and remainder; sum is below 256.
    always_comb
    begin
        sec_sum = sec_reg + item.value_seconds;
        if (sec_sum >= 8'd240)
            sec_carry = 3'd4;
        else if (sec_sum >= 8'd180)
            sec_carry = 3'd3;
        else if (sec_sum >= 8'd120)
            sec_carry = 3'd2;
        else if (sec_sum >= 8'd60)
            sec_carry = 3'd1;
        else
            sec_carry = 3'd0;
        sec_rem   = sec_sum - (TimeWidth'(sec_carry) * 8'd60);
        min_sum   = min_reg + item.value_minutes;
        carry_sum = min_reg + TimeWidth'(sec_carry);
    end

    always_comb
    begin
        count_next = count_reg;
        min_next   = min_reg;
        sec_next   = sec_reg;
        run_next   = run_reg;
        arm_next   = arm_reg;
        step       = 1'b0;
        case (req_t'(item.req_type))
            REQ_TICK:
            begin
                if (run_reg)
                begin
                    if (count_reg == compare_top_reg)
                    begin
                        count_next = '0;
                        if (arm_reg)
                        begin
                            step = 1'b1;
                            if (min_reg != '0)
                            begin
                                if (sec_reg == '0)
                                begin
                                    sec_next = SecondsTop;
                                    min_next = min_reg - 1'b1;
                                end
                                else
                                begin
                                    sec_next = sec_reg - 1'b1;
                                end
                            end
                            else if (sec_reg != '0)
                            begin
                                sec_next = sec_reg - 1'b1;
                            end
                            else
                            begin
                                arm_next = 1'b0;
                            end
                        end
                    end
                    else
                    begin
                        count_next = count_reg + 1'b1;
                    end
                end
            end
            REQ_SET:
            begin
                min_next   = item.value_minutes;
                sec_next   = item.value_seconds;
                count_next = '0;
                run_next   = 1'b1;
                arm_next   = 1'b1;
            end
            REQ_ADD_MIN:
            begin
                if (min_sum < max_minutes_reg)
                begin
                    min_next = min_sum;
                end
                else
                begin
                    min_next = max_minutes_reg;
                    sec_next = '0;
                end
            end
            REQ_ADD_SEC:
            begin
                // ignored once minutes are at the ceiling
                if (min_reg < max_minutes_reg)
                begin
                    if (carry_sum < max_minutes_reg)
                    begin
                        min_next = carry_sum;
                        sec_next = sec_rem;
                    end
                    else
                    begin
                        min_next = max_minutes_reg;
                        sec_next = '0;
                    end
                end
            end
            REQ_CLEAR:
            begin
                min_next = '0;
                sec_next = '0;
            end
            REQ_PAUSE:
            begin
                run_next = 1'b0;
            end
            REQ_RESUME:
            begin
                run_next = 1'b1;
            end
            default:
            begin
                step = 1'b0;
            end
        endcase
    end

    assign result.minutes     = min_next;
    assign result.seconds     = sec_next;
    assign result.is_zero     = (min_next == '0) && (sec_next == '0);
    assign result.running     = run_next;
    assign result.armed       = arm_next;
    assign result.second_step = step;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            compare_top_reg <= CompareTopReset;
            max_minutes_reg <= MaxMinutesReset;
        end
        else if (cfg_we)
        begin
            case (cfg_idx_t'(cfg_index))
                CFG_COMPARE_TOP: compare_top_reg <= cfg_data;
                CFG_MAX_MINUTES: max_minutes_reg <= cfg_data[TimeWidth-1:0];
                default:         compare_top_reg <= compare_top_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            min_reg   <= '0;
            sec_reg   <= '0;
            run_reg   <= 1'b0;
            arm_reg   <= 1'b0;
        end
        else if (advance)
        begin
            count_reg <= count_next;
            min_reg   <= min_next;
            sec_reg   <= sec_next;
            run_reg   <= run_next;
            arm_reg   <= arm_next;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/msct_output_stage.sv =====
// Result register: holds one result word until the consumer takes it.
`default_nettype none

module msct_output_stage
    import msct_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  item_valid,
    input  result_t                    result,
    output logic                       advance,
    output logic                       out_valid,
    input  wire logic                  out_stall,
    output logic [TimeWidth-1:0]       minutes,
    output logic [TimeWidth-1:0]       seconds,
    output logic                       is_zero,
    output logic                       running,
    output logic                       armed,
    output logic                       second_step
);

    logic    valid_reg;
    result_t result_reg;
    logic    can_load;

    assign can_load = !valid_reg || !out_stall;
    assign advance  = item_valid && can_load;

    assign out_valid   = valid_reg;
    assign minutes     = result_reg.minutes;
    assign seconds     = result_reg.seconds;
    assign is_zero     = result_reg.is_zero;
    assign running     = result_reg.running;
    assign armed       = result_reg.armed;
    assign second_step = result_reg.second_step;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (can_load)
        begin
            valid_reg <= item_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            result_reg <= result;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/minute_second_countdown_timer.sv =====
// Minutes:seconds countdown timer with clear-on-match prescale counter.
// Pipeline: input register, then result register; out_valid rises once the result
// register loads the word that the input register accepted.
// Throughput: one word per cycle unless out_stall backs up the pipe; the next state is one short add/compare pass.
// Reset (rst_n, async, active low): time 0:00, stopped, disarmed, counter zero,
// compare_top 14399, max_minutes 80; pipeline emptied.
`default_nettype none

module minute_second_countdown_timer
    import msct_pkg::*;
(
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic                    cfg_we,
    input  wire logic [CfgIdxWidth-1:0]  cfg_index,
    input  wire logic [CfgDataWidth-1:0] cfg_data,
    input  wire logic                    in_valid,
    output logic                         in_stall,
    input  wire logic [ReqWidth-1:0]     req_type,
    input  wire logic [TimeWidth-1:0]    value_minutes,
    input  wire logic [TimeWidth-1:0]    value_seconds,
    output logic                         out_valid,
    input  wire logic                    out_stall,
    output logic [TimeWidth-1:0]         minutes,
    output logic [TimeWidth-1:0]         seconds,
    output logic                         is_zero,
    output logic                         running,
    output logic                         armed,
    output logic                         second_step
);

    logic    advance;
    logic    item_valid;
    item_t   item;
    result_t result;

    msct_input_stage u_input (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .req_type      (req_type),
        .value_minutes (value_minutes),
        .value_seconds (value_seconds),
        .advance       (advance),
        .item_valid    (item_valid),
        .item          (item)
    );

    msct_engine u_engine (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .advance   (advance),
        .item      (item),
        .result    (result)
    );

    msct_output_stage u_output (
        .clk         (clk),
        .rst_n       (rst_n),
        .item_valid  (item_valid),
        .result      (result),
        .advance     (advance),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .minutes     (minutes),
        .seconds     (seconds),
        .is_zero     (is_zero),
        .running     (running),
        .armed       (armed),
        .second_step (second_step)
    );

endmodule

`default_nettype wire

// ===== verif/tb_minute_second_countdown_timer.sv =====
// Self-checking testbench for the minutes:seconds countdown timer.
`default_nettype none

module tb_minute_second_countdown_timer import msct_pkg::*; ;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int PipeLatency = 2;
    localparam int CycleLimit = 1_000_000;
    localparam int MaxIdle = 9;
    localparam int SecondsPerMinute = 60;
    localparam logic [ReqWidth-1:0] ReqUnused = 3'd7;
    localparam logic [CfgIdxWidth-1:0] CfgIdxSpareLo = 2'd2;
    localparam logic [CfgIdxWidth-1:0] CfgIdxSpareHi = 2'd3;

    typedef struct {
        item_t       word;
        int unsigned gap;
        bit          drain;
    } timer_cmd_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_we = 1'b0;
    logic [CfgIdxWidth-1:0] cfg_index = '0;
    logic [CfgDataWidth-1:0] cfg_data = '0;
    logic in_valid = 1'b0;
    logic in_stall;
    logic [ReqWidth-1:0] req_type = '0;
    logic [TimeWidth-1:0] value_minutes = '0;
    logic [TimeWidth-1:0] value_seconds = '0;
    logic out_valid;
    logic out_stall = 1'b0;
    logic [TimeWidth-1:0] minutes;
    logic [TimeWidth-1:0] seconds;
    logic is_zero;
    logic running;
    logic armed;
    logic second_step;

    minute_second_countdown_timer uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .req_type      (req_type),
        .value_minutes (value_minutes),
        .value_seconds (value_seconds),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .minutes       (minutes),
        .seconds       (seconds),
        .is_zero       (is_zero),
        .running       (running),
        .armed         (armed),
        .second_step   (second_step)
    );

    always #2 clk = ~clk;

    timer_cmd_t pending_cmds[$];
    result_t    expected_times[$];

    // timer state mirror
    logic [CountWidth-1:0] prescale_m = '0;
    logic [TimeWidth-1:0]  mins_m = '0;
    logic [TimeWidth-1:0]  secs_m = '0;
    logic                  run_m = 1'b0;
    logic                  arm_m = 1'b0;
    logic [CountWidth-1:0] cmp_top_m = CompareTopReset;
    logic [TimeWidth-1:0]  max_min_m = MaxMinutesReset;

    int unsigned words_queued = 0;
    int unsigned words_sent = 0;
    int unsigned results_checked = 0;
    int unsigned steps_seen = 0;
    int unsigned err_count = 0;
    int unsigned cycle_count = 0;
    bit          fast_lane = 1'b0;
    bit          calm_sender = 1'b0;

    function automatic void bump_minutes(logic [TimeWidth-1:0] amount);
        logic [TimeWidth-1:0] total;
        total = amount + mins_m;
        if (total < max_min_m)
            mins_m = total;
        else
        begin
            mins_m = max_min_m;
            secs_m = '0;
        end
    endfunction

    function automatic result_t timer_next(item_t w);
        result_t              r;
        logic [TimeWidth-1:0] total;
        logic                 step;
        step = 1'b0;
        case (w.req_type)
            REQ_TICK:
                if (run_m)
                begin
                    if (prescale_m == cmp_top_m)
                    begin
                        prescale_m = '0;
                        if (arm_m)
                        begin
                            step = 1'b1;
                            if (mins_m != 0)
                            begin
                                if (secs_m == 0)
                                begin
                                    secs_m = SecondsTop;
                                    mins_m = mins_m - 1'b1;
                                end
                                else
                                    secs_m = secs_m - 1'b1;
                            end
                            else if (secs_m != 0)
                                secs_m = secs_m - 1'b1;
                            else
                                arm_m = 1'b0;
                        end
                    end
                    else
                        prescale_m = prescale_m + 1'b1;
                end
            REQ_SET:
            begin
                mins_m = w.value_minutes;
                secs_m = w.value_seconds;
                prescale_m = '0;
                run_m = 1'b1;
                arm_m = 1'b1;
            end
            REQ_ADD_MIN: bump_minutes(w.value_minutes);
            REQ_ADD_SEC:
            begin
                total = w.value_seconds + secs_m;
                if (mins_m < max_min_m)
                begin
                    if (total > SecondsTop)
                    begin
                        secs_m = TimeWidth'(total % SecondsPerMinute);
                        bump_minutes(TimeWidth'(total / SecondsPerMinute));
                    end
                    else
                        secs_m = total;
                end
            end
            REQ_CLEAR: begin mins_m = '0; secs_m = '0; end
            REQ_PAUSE: run_m = 1'b0;
            REQ_RESUME: run_m = 1'b1;
            default: ;
        endcase
        r.minutes = mins_m;
        r.seconds = secs_m;
        r.is_zero = (mins_m == 0) && (secs_m == 0);
        r.running = run_m;
        r.armed = arm_m;
        r.second_step = step;
        return r;
    endfunction

    // sender
    int unsigned idle_cnt;
    timer_cmd_t  head_cmd;

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            req_type <= '0;
            value_minutes <= '0;
            value_seconds <= '0;
            idle_cnt <= 0;
        end
        else
        begin
            if (in_valid && !in_stall)
            begin
                expected_times.push_back(
                    timer_next(item_t'({req_type, value_minutes, value_seconds})));
                words_sent++;
            end
            if (!in_valid || !in_stall)
            begin
                if (pending_cmds.size() == 0 ||
                    (pending_cmds[0].drain && expected_times.size() != 0))
                    in_valid <= 1'b0;
                else if (idle_cnt < pending_cmds[0].gap)
                begin
                    idle_cnt <= idle_cnt + 1;
                    in_valid <= 1'b0;
                end
                else
                begin
                    head_cmd = pending_cmds.pop_front();
                    req_type <= head_cmd.word.req_type;
                    value_minutes <= head_cmd.word.value_minutes;
                    value_seconds <= head_cmd.word.value_seconds;
                    in_valid <= 1'b1;
                    idle_cnt <= 0;
                end
            end
        end
    end

    // receiver and checker
    task automatic check_field(string name, logic [7:0] want_v, logic [7:0] got_v);
        if (got_v !== want_v)
        begin
            $display("%0t: %s expected %0d, got %0d", $time, name, want_v, got_v);
            err_count++;
        end
    endtask

    int unsigned stall_left;
    int unsigned stall_draw;
    result_t     got_time;
    result_t     want_time;

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_stall <= 1'b0;
            stall_left <= 0;
        end
        else if (out_valid && !out_stall)
        begin
            got_time = {minutes, seconds, is_zero, running, armed, second_step};
            results_checked++;
            if (expected_times.size() == 0)
            begin
                $display("%0t: unexpected word %p", $time, got_time);
                err_count++;
            end
            else
            begin
                want_time = expected_times.pop_front();
                check_field("minutes", want_time.minutes, got_time.minutes);
                check_field("seconds", want_time.seconds, got_time.seconds);
                check_field("is_zero", want_time.is_zero, got_time.is_zero);
                check_field("running", want_time.running, got_time.running);
                check_field("armed", want_time.armed, got_time.armed);
                check_field("second_step", want_time.second_step, got_time.second_step);
            end
            if (got_time.second_step === 1'b1)
                steps_seen++;
            // bursts of back-to-back acceptance between stalled stretches
            if (fast_lane || (results_checked % 64) < 16)
                stall_draw = 0;
            else
                stall_draw = $urandom_range(0, MaxIdle);
            stall_left <= stall_draw;
            out_stall <= (stall_draw != 0);
        end
        else if (stall_left > 0)
        begin
            stall_left <= stall_left - 1;
            out_stall <= (stall_left > 1);
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count == CycleLimit)
        begin
            $display("%0t: timeout, %0d of %0d words sent, %0d results pending",
                     $time, words_sent, words_queued, expected_times.size());
            $display("tb_minute_second_countdown_timer: done, errors");
            $finish;
        end
    end

    task automatic queue_word(logic [ReqWidth-1:0] req, logic [TimeWidth-1:0] vm,
                              logic [TimeWidth-1:0] vs, bit drain = 1'b0);
        timer_cmd_t c;
        c.word.req_type = req;
        c.word.value_minutes = vm;
        c.word.value_seconds = vs;
        c.gap = (fast_lane || calm_sender) ? 0 : $urandom_range(0, MaxIdle);
        c.drain = drain;
        pending_cmds.push_back(c);
        words_queued++;
    endtask

    // wait until every queued word is through and the pipe is empty
    task automatic settle();
        while (words_sent != words_queued || expected_times.size() != 0)
            @(posedge clk);
        repeat (PipeLatency + 2) @(posedge clk);
    endtask

    task automatic write_cfg(logic [CfgIdxWidth-1:0] idx, logic [CfgDataWidth-1:0] val);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        case (idx)
            CFG_COMPARE_TOP: cmp_top_m = val;
            CFG_MAX_MINUTES: max_min_m = val[TimeWidth-1:0];
            default: ;
        endcase
        @(posedge clk);
    endtask

    task automatic run_phase(logic [CountWidth-1:0] cmp, logic [TimeWidth-1:0] max_min,
                             int n_words);
        int                   pick;
        logic [TimeWidth-1:0] vm;
        logic [TimeWidth-1:0] vs;
        logic [ReqWidth-1:0]  req;
        settle();
        write_cfg(CFG_COMPARE_TOP, cmp);
        write_cfg(CFG_MAX_MINUTES, {8'd0, max_min});
        for (int i = 0; i < n_words; i++)
        begin
            if (i % 20 == 0)
                calm_sender = ($urandom_range(0, 3) == 0);
            pick = $urandom_range(0, 99);
            vm = ($urandom_range(0, 4) == 0) ? 8'($urandom) : 8'($urandom_range(0, 2));
            vs = ($urandom_range(0, 4) == 0) ? 8'($urandom) : 8'($urandom_range(0, 10));
            if (pick < 55)
                req = REQ_TICK;
            else if (pick < 65)
                req = REQ_SET;
            else if (pick < 72)
                req = REQ_ADD_MIN;
            else if (pick < 79)
                req = REQ_ADD_SEC;
            else if (pick < 84)
                req = REQ_CLEAR;
            else if (pick < 89)
                req = REQ_PAUSE;
            else if (pick < 96)
                req = REQ_RESUME;
            else
                req = ReqUnused;
            queue_word(req, vm, vs, i == n_words / 2);
        end
        calm_sender = 1'b0;
    endtask

    initial
    begin
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: every tick matches
        write_cfg(CFG_COMPARE_TOP, 16'd0);
        write_cfg(CFG_MAX_MINUTES, 16'd80);
        queue_word(REQ_TICK, 8'd0, 8'd0);           // stopped, nothing moves
        queue_word(ReqUnused, 8'd255, 8'd255);
        queue_word(REQ_SET, 8'd1, 8'd0);
        queue_word(REQ_TICK, 8'd0, 8'd0);           // minute borrow
        queue_word(REQ_SET, 8'd0, 8'd61);
        queue_word(REQ_TICK, 8'd0, 8'd0);           // seconds above 59 count down
        queue_word(REQ_SET, 8'd0, 8'd0);
        queue_word(REQ_TICK, 8'd0, 8'd0);           // match at 0:00 disarms
        queue_word(REQ_TICK, 8'd0, 8'd0);
        queue_word(REQ_ADD_MIN, 8'd255, 8'd0);      // saturates
        queue_word(REQ_ADD_SEC, 8'd0, 8'd255);      // ignored at max minutes
        queue_word(REQ_CLEAR, 8'd0, 8'd0);
        queue_word(REQ_ADD_SEC, 8'd0, 8'd255);      // carry into minutes
        queue_word(REQ_ADD_MIN, 8'd200, 8'd0);
        queue_word(REQ_SET, 8'd255, 8'd255);
        queue_word(REQ_PAUSE, 8'd0, 8'd0);
        queue_word(REQ_TICK, 8'd0, 8'd0);
        queue_word(REQ_RESUME, 8'd0, 8'd0);
        queue_word(REQ_TICK, 8'd0, 8'd0);
        queue_word(REQ_ADD_MIN, 8'd1, 8'd0);        // 8-bit wrap of the sum
        queue_word(REQ_ADD_SEC, 8'd0, 8'd10);       // 8-bit wrap, no carry
        queue_word(REQ_CLEAR, 8'd0, 8'd0);
        queue_word(REQ_ADD_SEC, 8'd0, 8'd59);
        queue_word(REQ_ADD_SEC, 8'd0, 8'd1);

        run_phase(16'd1, 8'd80, 100);
        run_phase(16'd0, 8'd255, 90);
        run_phase(16'd3, 8'd1, 100);
        run_phase(16'($urandom_range(0, 5)), 8'($urandom_range(1, 255)), 100);
        settle();
        write_cfg(CfgIdxSpareLo, 16'h0001);         // unused indexes must not land
        write_cfg(CfgIdxSpareHi, 16'hFFFF);
        run_phase(16'hFFFF, 8'd3, 60);
        run_phase(CompareTopReset, MaxMinutesReset, 40);

        // lower compare_top under a running counter: it keeps counting past it
        settle();
        fast_lane = 1'b1;
        write_cfg(CFG_COMPARE_TOP, 16'd40000);
        queue_word(REQ_SET, 8'd0, 8'd5);
        repeat (30) queue_word(REQ_TICK, 8'd0, 8'd0);
        settle();
        write_cfg(CFG_COMPARE_TOP, 16'd20);
        repeat (20) queue_word(REQ_TICK, 8'd0, 8'd0);

        settle();
        $display("%0d words sent, %0d results checked, %0d one-second steps seen",
                 words_sent, results_checked, steps_seen);
        $display("covered compare_top 0..65535, max_minutes 1..255, spare indexes, %s",
                 "counter running past compare_top");
        if (err_count == 0)
            $display("tb_minute_second_countdown_timer: done, clean");
        else
            $display("tb_minute_second_countdown_timer: done, errors");
        $finish;
    end

endmodule

`default_nettype wire

// ===== files.f =====
rtl/msct_pkg.sv
rtl/msct_input_stage.sv
rtl/msct_engine.sv
rtl/msct_output_stage.sv
rtl/minute_second_countdown_timer.sv
verif/tb_minute_second_countdown_timer.sv
